>>> hdl/cmaf_pkg.sv
// shared types and constants for the cascaded moving average filter
// no dependencies; imported by the datapath, controller and top level
`default_nettype none

package cmaf_pkg;

    localparam int FIELD_BITS     = 24;
    localparam int MODE_BITS      = 2;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 6;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODE   = 2'd1;

    localparam logic [MODE_BITS-1:0] MODE_SINGLE  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_CASCADE = 2'd1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_WALK1  = 6'b000010,
        ST_DIV1   = 6'b000100,
        ST_WALK2  = 6'b001000,
        ST_DIV2   = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        DIV_S1  = 2'd0,
        DIV_S2  = 2'd1,
        DIV_MIX = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic     walk1_start;
        logic     walk2_start;
        logic     div_start;
        div_sel_t div_sel;
        logic     load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic div_done;
        logic out_full;
        logic mode_mix;
        logic mode_single;
    } ctrl_stat_t;

endpackage

`default_nettype wire

>>> hdl/cmaf_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module cmaf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/cmaf_datapath.sv
// datapath: config registers, two delay-line rams with walker, serial divider, output register
// depends on cmaf_pkg and cmaf_ram
`default_nettype none

module cmaf_datapath import cmaf_pkg::*; #(
    parameter int MAX_WINDOW  = 32,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire ctrl_cmd_t                 cmd,
    output ctrl_stat_t                     stat,
    input  wire logic [FIELD_BITS-1:0]     sample,
    input  wire logic                      cfg_valid,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                      out_ready,
    output logic                           out_valid,
    output logic      [FIELD_BITS-1:0]     filtered
);

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int NW = $clog2(MAX_WINDOW + 1);
    localparam int SB = SAMPLE_BITS;
    localparam int SW = SB + AW;
    localparam int DW = SW + 1;
    localparam int DV = NW + 1;
    localparam int CW = $clog2(DW + 1);
    localparam int WIN_RESET = (16 > MAX_WINDOW) ? MAX_WINDOW : 16;

    logic [NW-1:0]         win_reg, win_next;
    logic [MODE_BITS-1:0]  mode_reg, mode_next;
    logic                  stage_reg, stage_next;
    logic                  issue_reg, issue_next;
    logic [AW-1:0]         rd_cnt_reg, rd_cnt_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic [AW-1:0]         rd_k_reg, rd_k_next;
    logic                  rvld_reg, rvld_next;
    logic                  fin_reg, fin_next;
    logic                  walk_done_reg, walk_done_next;
    logic [SB-1:0]         x_reg, x_next;
    logic [SW-1:0]         acc_reg, acc_next;
    logic [SW-1:0]         s1_reg, s1_next;
    logic [SW-1:0]         s2_reg, s2_next;
    logic [MAX_WINDOW-1:0] vld1_reg, vld1_next;
    logic [MAX_WINDOW-1:0] vld2_reg, vld2_next;
    logic                  div_busy_reg, div_busy_next;
    logic [CW-1:0]         div_cnt_reg, div_cnt_next;
    logic                  div_done_reg, div_done_next;
    logic [DW-1:0]         quo_reg, quo_next;
    logic [DV-1:0]         rem_reg, rem_next;
    logic [DV-1:0]         dvs_reg, dvs_next;
    logic                  out_valid_reg, out_valid_next;
    logic [SB-1:0]         out_reg, out_next;

    logic [AW-1:0]         nm1;
    logic [SB-1:0]         rd1, rd2, rd_word;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [SB-1:0]         wr_data;
    logic [DV:0]           trial;
    logic                  ge;
    logic [SB-1:0]         sample_x;

    cmaf_ram #(.WIDTH(SB), .DEPTH(MAX_WINDOW)) u_input_line (
        .clk   (clk),
        .we    (wr_en & ~stage_reg),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_cnt_reg),
        .rdata (rd1)
    );

    cmaf_ram #(.WIDTH(SB), .DEPTH(MAX_WINDOW)) u_average_line (
        .clk   (clk),
        .we    (wr_en & stage_reg),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_cnt_reg),
        .rdata (rd2)
    );

    always_comb
    begin
        nm1      = AW'(win_reg - NW'(1));
        sample_x = SB'(sample);
        rd_word  = rvld_reg ? (stage_reg ? rd2 : rd1) : '0;

        // delay line write port: shift down, then place the new word at the top
        wr_en   = rd_pend_reg && (rd_k_reg != '0);
        wr_addr = rd_k_reg - AW'(1);
        wr_data = (rd_k_reg == nm1) ? x_reg : rd_word;
        if (fin_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = nm1;
            wr_data = x_reg;
        end

        win_next       = win_reg;
        mode_next      = mode_reg;
        stage_next     = stage_reg;
        issue_next     = issue_reg;
        rd_cnt_next    = rd_cnt_reg;
        rd_pend_next   = issue_reg;
        rd_k_next      = rd_cnt_reg;
        rvld_next      = stage_reg ? vld2_reg[rd_cnt_reg] : vld1_reg[rd_cnt_reg];
        fin_next       = rd_pend_reg && (rd_k_reg == nm1);
        walk_done_next = fin_reg;
        x_next         = x_reg;
        acc_next       = acc_reg;
        s1_next        = s1_reg;
        s2_next        = s2_reg;
        vld1_next      = vld1_reg;
        vld2_next      = vld2_reg;
        div_busy_next  = div_busy_reg;
        div_cnt_next   = div_cnt_reg;
        div_done_next  = 1'b0;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        // config writes
        if (cfg_valid)
        begin
            if (cfg_index == REG_WINDOW)
            begin
                if (cfg_data == '0)
                begin
                    win_next = NW'(1);
                end
                else if (int'(cfg_data) > MAX_WINDOW)
                begin
                    win_next = NW'(MAX_WINDOW);
                end
                else
                begin
                    win_next = NW'(cfg_data);
                end
            end
            else if (cfg_index == REG_MODE)
            begin
                mode_next = cfg_data[MODE_BITS-1:0];
            end
        end

        // read sequencer
        if (issue_reg)
        begin
            if (rd_cnt_reg == nm1)
            begin
                issue_next = 1'b0;
            end
            else
            begin
                rd_cnt_next = rd_cnt_reg + AW'(1);
            end
        end

        if (rd_pend_reg && (rd_k_reg != nm1))
        begin
            acc_next = acc_reg + SW'(rd_word);
        end

        if (wr_en)
        begin
            if (stage_reg)
            begin
                vld2_next[wr_addr] = 1'b1;
            end
            else
            begin
                vld1_next[wr_addr] = 1'b1;
            end
        end

        if (fin_reg)
        begin
            if (stage_reg)
            begin
                s2_next = acc_reg;
            end
            else
            begin
                s1_next = acc_reg;
            end
        end

        if (cmd.walk1_start)
        begin
            stage_next  = 1'b0;
            x_next      = sample_x;
            acc_next    = SW'(sample_x);
            issue_next  = 1'b1;
            rd_cnt_next = '0;
        end
        else if (cmd.walk2_start)
        begin
            stage_next  = 1'b1;
            x_next      = quo_reg[SB-1:0];
            acc_next    = SW'(quo_reg[SB-1:0]);
            issue_next  = 1'b1;
            rd_cnt_next = '0;
        end

        // restoring divider, one quotient bit per cycle
        trial = {rem_reg, quo_reg[DW-1]};
        ge    = trial >= {1'b0, dvs_reg};
        if (cmd.div_start)
        begin
            div_busy_next = 1'b1;
            div_cnt_next  = CW'(DW);
            rem_next      = '0;
            case (cmd.div_sel)
                DIV_S1:
                begin
                    quo_next = DW'(s1_reg);
                    dvs_next = {1'b0, win_reg};
                end
                DIV_S2:
                begin
                    quo_next = DW'(s2_reg);
                    dvs_next = {1'b0, win_reg};
                end
                DIV_MIX:
                begin
                    quo_next = DW'(s1_reg) + DW'(s2_reg);
                    dvs_next = {win_reg, 1'b0};
                end
                default:
                begin
                    quo_next = DW'(s1_reg);
                    dvs_next = {1'b0, win_reg};
                end
            endcase
        end
        else if (div_busy_reg)
        begin
            rem_next     = ge ? DV'(trial - {1'b0, dvs_reg}) : DV'(trial);
            quo_next     = {quo_reg[DW-2:0], ge};
            div_cnt_next = div_cnt_reg - CW'(1);
            if (div_cnt_reg == CW'(1))
            begin
                div_busy_next = 1'b0;
                div_done_next = 1'b1;
            end
        end

        // output register
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            out_next       = (mode_reg == MODE_SINGLE) ? x_reg : quo_reg[SB-1:0];
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= NW'(WIN_RESET);
            mode_reg      <= MODE_CASCADE;
            stage_reg     <= 1'b0;
            issue_reg     <= 1'b0;
            rd_pend_reg   <= 1'b0;
            fin_reg       <= 1'b0;
            walk_done_reg <= 1'b0;
            vld1_reg      <= '0;
            vld2_reg      <= '0;
            div_busy_reg  <= 1'b0;
            div_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            win_reg       <= win_next;
            mode_reg      <= mode_next;
            stage_reg     <= stage_next;
            issue_reg     <= issue_next;
            rd_pend_reg   <= rd_pend_next;
            fin_reg       <= fin_next;
            walk_done_reg <= walk_done_next;
            vld1_reg      <= vld1_next;
            vld2_reg      <= vld2_next;
            div_busy_reg  <= div_busy_next;
            div_done_reg  <= div_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_cnt_reg  <= rd_cnt_next;
        rd_k_reg    <= rd_k_next;
        rvld_reg    <= rvld_next;
        x_reg       <= x_next;
        acc_reg     <= acc_next;
        s1_reg      <= s1_next;
        s2_reg      <= s2_next;
        div_cnt_reg <= div_cnt_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        out_reg     <= out_next;
    end

    assign stat.walk_done   = walk_done_reg;
    assign stat.div_done    = div_done_reg;
    assign stat.out_full    = out_valid_reg;
    assign stat.mode_mix    = mode_reg[1];
    assign stat.mode_single = (mode_reg == MODE_SINGLE);

    assign out_valid = out_valid_reg;
    assign filtered  = FIELD_BITS'(out_reg);

endmodule

`default_nettype wire

>>> hdl/cmaf_controller.sv
// controller state machine sequencing the two stage walks and one or two divides per transfer
// depends on cmaf_pkg
`default_nettype none

module cmaf_controller import cmaf_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       out_ready,
    input  wire ctrl_stat_t stat,
    output logic            in_ready,
    output ctrl_cmd_t       cmd
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_S1;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.walk1_start = 1'b1;
                    state_next      = ST_WALK1;
                end
            end
            ST_WALK1:
            begin
                if (stat.walk_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_S1;
                    state_next    = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                if (stat.div_done)
                begin
                    cmd.walk2_start = 1'b1;
                    state_next      = ST_WALK2;
                end
            end
            ST_WALK2:
            begin
                if (stat.walk_done)
                begin
                    if (stat.mode_mix)
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DIV_MIX;
                        state_next    = ST_DIV2;
                    end
                    else if (stat.mode_single)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DIV_S2;
                        state_next    = ST_DIV2;
                    end
                end
            end
            ST_DIV2:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!stat.out_full || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

>>> hdl/cascaded_moving_average_filter_top.sv
// Cascaded moving average filter: two boxcar stages of N = window_length samples
// (clamped to 1..MAX_WINDOW), output mode selects stage one, stage two, or the
// combined sum of both stages divided by 2N. One sample is processed at a time;
// an item's processing time is set by walking each delay line through one ram read
// port per cycle and by the one-bit-per-cycle divider. Single-average mode skips
// the second divide. A finished result waits in an output register while the next
// sample is taken in.
// Depends on cmaf_pkg, cmaf_controller, cmaf_datapath and cmaf_ram.
`default_nettype none

module cascaded_moving_average_filter_top import cmaf_pkg::*; #(
    parameter int MAX_WINDOW  = 32,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [FIELD_BITS-1:0]     sample,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic      [FIELD_BITS-1:0]     filtered,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    assign cfg_ready = 1'b1;

    cmaf_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    cmaf_datapath #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .sample    (sample),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .filtered  (filtered)
    );

endmodule

`default_nettype wire

>>> dv/cascaded_moving_average_filter_top_tb.sv
// self-checking testbench for cascaded_moving_average_filter_top: directed table, then random phases
// depends on cmaf_pkg and the filter rtl; results are checked against an in-bench boxcar predictor
`default_nettype none

module cascaded_moving_average_filter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cmaf_pkg::*;

    localparam int HIST_DEPTH    = 32;
    localparam int MAX_GAP       = 13;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 200;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int CYCLE_LIMIT   = 1500000;

    localparam logic [MODE_BITS-1:0] MODE_MIXED     = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_MIXED_ALT = 2'd3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;

    localparam logic ROW_SAMPLE = 1'b0;
    localparam logic ROW_CFG    = 1'b1;
    localparam logic PREDICTED  = 1'b0;
    localparam logic TYPED      = 1'b1;

    localparam logic [FIELD_BITS-1:0] SAMPLE_MAX = {FIELD_BITS{1'b1}};

    typedef struct packed {
        logic                      kind;
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [CFG_DATA_BITS-1:0]  dat;
        logic [FIELD_BITS-1:0]     smp;
        logic                      typed;
        logic [FIELD_BITS-1:0]     want;
    } stim_row_t;

    localparam int NUM_ROWS = 32;

    localparam stim_row_t DIRECTED [NUM_ROWS] = '{
        '{ROW_SAMPLE, REG_WINDOW,  6'd0,               24'h000000, TYPED,     24'h000000},
        '{ROW_SAMPLE, REG_WINDOW,  6'd0,               24'hFFFFFF, PREDICTED, 24'h000000},
        // window of zero is stored as one
        '{ROW_CFG,    REG_WINDOW,  6'd0,               24'h000000, PREDICTED, 24'h000000},
        '{ROW_CFG,    REG_MODE,    6'(MODE_SINGLE),    24'h000000, PREDICTED, 24'h000000},
        '{ROW_SAMPLE, REG_WINDOW,  6'd0,               24'hFFFFFF, TYPED,     24'hFFFFFF},
        '{ROW_SAMPLE, REG_WINDOW,  6'd0,               24'h000000, TYPED,     24'h000000},
        '{ROW_SAMPLE, REG_WINDOW,  6'd0,               24'h123456, TYPED,     24'h123456},
        '{ROW_CFG,    REG_MODE,    6'(MODE_CASCADE),   24'h000000, PREDICTED, 24'h000000},
        '{ROW_SAMPLE, REG_WINDOW,  6'd0,               24'hFFFFFF, TYPED,     24'hFFFFFF},
        '{ROW_CFG,    REG_MODE,    6'(MODE_MIXED),     24'h000000, PREDICTED, 24'h000000},
        '{ROW_SAMPLE, REG_WINDOW,  6'd0,               24'h800001, TYPED,     24'h800001},
        // mode three acts as the mixed sum
        '{ROW_CFG,    REG_MODE,    6'(MODE_MIXED_ALT), 24'h000000, PREDICTED, 24'h000000},
        '{ROW_SAMPLE, REG_WINDOW,  6'd0,               24'hFFFFFF, TYPED,     24'hFFFFFF},
        // indexes past the register list are ignored
        '{ROW_CFG,    REG_SPARE_A, 6'h3F,              24'h000000, PREDICTED, 24'h000000},
        '{ROW_CFG,    REG_SPARE_B, 6'h00,              24'h000000, PREDICTED, 24'h000000},
        '{ROW_SAMPLE, REG_WINDOW,  6'd0,               24'hAAAAAA, TYPED,     24'hAAAAAA},
        // window above the maximum is stored as the maximum
        '{ROW_CFG,    REG_WINDOW,  6'd63,              24'h000000, PREDICTED, 24'h000000},
        '{ROW_SAMPLE, REG_WINDOW,  6'd0,               24'hFFFFFF, PREDICTED, 24'h000000},
        '{ROW_SAMPLE, REG_WINDOW,  6'd0,               24'hFFFFFF, PREDICTED, 24'h000000},
        '{ROW_SAMPLE, REG_WINDOW,  6'd0,               24'h000001, PREDICTED, 24'h000000},
        '{ROW_CFG,    REG_MODE,    6'(MODE_SINGLE),    24'h000000, PREDICTED, 24'h000000},
        '{ROW_SAMPLE, REG_WINDOW,  6'd0,               24'hFFFFFF, PREDICTED, 24'h000000},
        // shrink after use, then grow so stale slots come back
        '{ROW_CFG,    REG_WINDOW,  6'd4,               24'h000000, PREDICTED, 24'h000000},
        '{ROW_SAMPLE, REG_WINDOW,  6'd0,               24'h555555, PREDICTED, 24'h000000},
        '{ROW_SAMPLE, REG_WINDOW,  6'd0,               24'hFFFFFF, PREDICTED, 24'h000000},
        '{ROW_CFG,    REG_WINDOW,  6'd32,              24'h000000, PREDICTED, 24'h000000},
        '{ROW_SAMPLE, REG_WINDOW,  6'd0,               24'h000000, PREDICTED, 24'h000000},
        '{ROW_CFG,    REG_MODE,    6'(MODE_MIXED),     24'h000000, PREDICTED, 24'h000000},
        '{ROW_SAMPLE, REG_WINDOW,  6'd0,               24'hFFFFFF, PREDICTED, 24'h000000},
        '{ROW_CFG,    REG_WINDOW,  6'd33,              24'h000000, PREDICTED, 24'h000000},
        '{ROW_CFG,    REG_MODE,    6'(MODE_CASCADE),   24'h000000, PREDICTED, 24'h000000},
        '{ROW_SAMPLE, REG_WINDOW,  6'd0,               24'h7FFFFF, PREDICTED, 24'h000000}
    };

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic [FIELD_BITS-1:0]     sample    = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [FIELD_BITS-1:0]     filtered;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    logic [FIELD_BITS-1:0] input_line   [HIST_DEPTH];
    logic [FIELD_BITS-1:0] average_line [HIST_DEPTH];
    logic [5:0]            win_len  = 6'd16;
    logic [MODE_BITS-1:0]  cur_mode = MODE_CASCADE;

    logic [FIELD_BITS-1:0] expected_filtered [$];
    int                    errors      = 0;
    int                    cycle_count = 0;
    bit                    calm        = 1'b0;

    cascaded_moving_average_filter_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .filtered  (filtered),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [FIELD_BITS-1:0] predict_filtered(input logic [FIELD_BITS-1:0] x);
        logic [63:0]           n;
        logic [63:0]           s1;
        logic [63:0]           s2;
        logic [FIELD_BITS-1:0] a1;
        int                    last;
        int                    j;
        n    = 64'(win_len);
        last = int'(win_len) - 1;
        input_line[last] = x;
        s1 = 64'(x);
        for (j = 0; j < last; j++)
        begin
            s1 += 64'(input_line[j]);
            input_line[j] = input_line[j + 1];
        end
        a1 = FIELD_BITS'(s1 / n);
        average_line[last] = a1;
        s2 = 64'(a1);
        for (j = 0; j < last; j++)
        begin
            s2 += 64'(average_line[j]);
            average_line[j] = average_line[j + 1];
        end
        if (cur_mode[1])
            return FIELD_BITS'((s1 + s2) / (2 * n));
        if (cur_mode == MODE_SINGLE)
            return a1;
        return FIELD_BITS'(s2 / n);
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_filtered.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] dat);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= dat;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_WINDOW)
        begin
            if (dat == 0)
                win_len = 6'd1;
            else if (dat > HIST_DEPTH)
                win_len = 6'(HIST_DEPTH);
            else
                win_len = dat;
        end
        else if (idx == REG_MODE)
            cur_mode = dat[MODE_BITS-1:0];
    endtask

    task automatic push_sample(input logic [FIELD_BITS-1:0] s, input logic typed,
                               input logic [FIELD_BITS-1:0] want);
        int                    gap;
        logic [FIELD_BITS-1:0] predicted;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        do @(posedge clk); while (!in_ready);
        predicted = predict_filtered(s);
        expected_filtered.push_back(typed ? want : predicted);
    endtask

    // result side: random stalls, check each transfer against the oldest expectation
    initial
    begin
        int                    stall;
        logic [FIELD_BITS-1:0] want;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (expected_filtered.size() == 0)
            begin
                $error("filtered: transfer with nothing expected, actual %0h", filtered);
                errors++;
            end
            else
            begin
                want = expected_filtered.pop_front();
                if (filtered !== want)
                begin
                    $error("filtered: expected %0h actual %0h", want, filtered);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int                    sent;
        int                    phase_len;
        int                    k;
        logic [CFG_DATA_BITS-1:0] wdat;
        logic [FIELD_BITS-1:0] s;
        for (k = 0; k < HIST_DEPTH; k++)
        begin
            input_line[k]   = '0;
            average_line[k] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[r])
        begin
            if (DIRECTED[r].kind == ROW_CFG)
                write_register(DIRECTED[r].idx, DIRECTED[r].dat);
            else
                push_sample(DIRECTED[r].smp, DIRECTED[r].typed, DIRECTED[r].want);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0:       wdat = 6'd0;
                1:       wdat = 6'd32;
                2:       wdat = 6'($urandom_range(33, 63));
                3:       wdat = 6'd1;
                default: wdat = 6'($urandom_range(2, 8));
            endcase
            if ($urandom_range(0, 4) != 0)
                write_register(REG_WINDOW, wdat);
            if ($urandom_range(0, 4) != 0)
                write_register(REG_MODE, 6'($urandom_range(0, 63)));
            if ($urandom_range(0, 5) == 0)
                write_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                               6'($urandom_range(0, 63)));
            phase_len = $urandom_range(40, 140);
            for (k = 0; k < phase_len; k++)
            begin
                case ($urandom_range(0, 7))
                    0:       s = '0;
                    1:       s = SAMPLE_MAX;
                    2:       s = SAMPLE_MAX - FIELD_BITS'($urandom_range(0, 255));
                    3:       s = FIELD_BITS'($urandom_range(0, 255));
                    default: s = FIELD_BITS'($urandom());
                endcase
                push_sample(s, PREDICTED, '0);
                if (k == phase_len / 2 && $urandom_range(0, 2) == 0)
                    wait_drained();
            end
            sent += phase_len;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && expected_filtered.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
